// File: sv/assert_macros.svh
// Assertion helper macros used by the aggregator core
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Concurrent implication check on the rising clock edge, off during reset
`define ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);
// Concurrent next-cycle implication check
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);
`endif

// File: sv/psva_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// psva_pkg
// Shared constants for the per-source value aggregator.
// ----------------------------------------------------------------------------
package psva_pkg;
   localparam logic [2:0] MODE_LAST = 3'd0;
   localparam logic [2:0] MODE_MIN  = 3'd1;
   localparam logic [2:0] MODE_MAX  = 3'd2;
   localparam logic [2:0] MODE_SUM  = 3'd3;
   localparam logic [2:0] MODE_AVG  = 3'd4;

   localparam logic [0:0] CSR_AGG_MODE = 1'b0;
   localparam logic [0:0] CSR_LIFETIME = 1'b1;

   localparam logic FUNC_REPORT = 1'b0;
   localparam logic FUNC_TICK   = 1'b1;

   localparam logic [7:0] LIFETIME_RESET = 8'd60;
endpackage
`default_nettype wire

// File: sv/per_source_value_aggregator_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// per_source_value_aggregator_core
// Source-keyed table of signed values with timeout and live aggregation.
// ----------------------------------------------------------------------------
// Usage:
//   req_ carries items: tuser = func (0 report, 1 tick), tdata = source_addr
//   in bits 31:0 and sample in bits 63:32. A report yields one rsp_ item;
//   a tick yields none. csr_ writes agg_mode (index 0) and entry_lifetime
//   (index 1); the user must write them only while idle (not enforced).
//   Entry address, value and timer live in one synchronous memory per
//   field, read one slot per cycle; live bits are flip-flops.
//   A report runs a search pass and then an aggregate pass over the slots,
//   plus one divide step per accumulator bit in average mode; a dropped
//   report ends after the search pass. A tick runs a read-decrement-write
//   sweep over the slots. One item is in work at a time, so a new item is
//   not accepted until the last one is through.
//   Reset clears the live bits, state and output flags and restores the
//   default settings; no clearing pass is needed. When the receiver stalls,
//   the result waits in the output register and the next input item is
//   still accepted and worked up to its own result.
// ----------------------------------------------------------------------------
module per_source_value_aggregator_core #(
   parameter int SLOTS = 16
) (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_tvalid,
   output logic        req_tready,
   input  wire  [63:0] req_tdata,   // source_addr[31:0], sample[63:32]
   input  wire         req_tuser,   // func
   output logic        rsp_tvalid,
   input  wire         rsp_tready,
   output logic [39:0] rsp_tdata,   // agg_value[31:0], changed, dropped,
                                    // live_count[38:34], zero pad
   input  wire         csr_valid,
   output logic        csr_ready,
   input  wire  [0:0]  csr_index,
   input  wire  [7:0]  csr_data
);
`include "assert_macros.svh"
   localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int CW = $clog2(SLOTS + 1);
   localparam int AW = 32 + CW;    // exact sum of all live values

   typedef enum logic [3:0] {
      ST_IDLE, ST_SRCH, ST_DECIDE, ST_WRITE, ST_AGG, ST_DIV, ST_OUT,
      ST_TICK, ST_TICKW
   } state_type;

   state_type state_ff;
   logic [2:0]  mode_ff;
   logic [7:0]  life_ff;
   logic [SLOTS-1:0] live_ff;
   logic        func_ff;
   logic [31:0] addr_ff, sample_ff;
   logic [IW:0] idx_ff;           // issue index
   logic [IW:0] ridx_ff;          // index of data now on the read port
   logic        rvalid_ff;
   logic [IW:0] hit_ff, free_ff;
   logic        changed_ff;
   logic [CW-1:0] n_ff;
   logic signed [31:0] best_ff;
   logic [31:0] wsum_ff;
   logic signed [AW-1:0] acc_ff;
   logic        first_ff;
   logic [AW-1:0] rem_ff, quo_ff, div_num_ff;
   logic        neg_ff;
   logic [5:0]  dcnt_ff;
   logic        obuf_ff;
   logic [39:0] odata_ff;
   logic        pend_ff;
   logic [39:0] pdata_ff;

   // memories
   logic [31:0] mem_addr [SLOTS];
   logic [31:0] mem_val  [SLOTS];
   logic [7:0]  mem_tmr  [SLOTS];
   logic [31:0] rd_addr, rd_val;
   logic [7:0]  rd_tmr;
   logic        we_rep, we_tmr;
   logic [IW-1:0] wr_idx, rd_idx;
   logic [7:0]  wr_tmr;

   assign rd_idx = idx_ff[IW-1:0];
   always_ff @(posedge clock) begin
      rd_addr <= mem_addr[rd_idx];
      rd_val  <= mem_val[rd_idx];
      rd_tmr  <= mem_tmr[rd_idx];
      if (we_rep) begin
         mem_addr[wr_idx] <= addr_ff;
         mem_val[wr_idx]  <= sample_ff;
      end
      if (we_tmr) mem_tmr[wr_idx] <= wr_tmr;
   end

   logic rd_live;
   assign rd_live = live_ff[ridx_ff[IW-1:0]];
   logic [7:0] tdec;
   assign tdec = (rd_tmr != 8'd0) ? rd_tmr - 8'd1 : 8'd0;

   always_comb begin
      we_rep = 1'b0; we_tmr = 1'b0; wr_idx = hit_ff[IW-1:0]; wr_tmr = life_ff;
      if (state_ff == ST_WRITE) begin
         we_rep = 1'b1; we_tmr = 1'b1;
      end else if (state_ff == ST_TICKW && rvalid_ff && rd_live) begin
         we_tmr = 1'b1; wr_idx = ridx_ff[IW-1:0]; wr_tmr = tdec;
      end
   end

   assign req_tready = (state_ff == ST_IDLE) && !pend_ff;
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = obuf_ff;
   assign rsp_tdata  = odata_ff;

   logic signed [AW-1:0] rv_ext;
   assign rv_ext = AW'(signed'(rd_val));
   logic [AW:0] dtrial;
   assign dtrial = {rem_ff, div_num_ff[AW-1]} - (AW+1)'(n_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         mode_ff  <= psva_pkg::MODE_LAST;
         life_ff  <= psva_pkg::LIFETIME_RESET;
         live_ff  <= '0;
         obuf_ff  <= 1'b0;
         pend_ff  <= 1'b0;
         rvalid_ff <= 1'b0;
      end else begin
         if (csr_valid) begin
            unique case (csr_index)
               psva_pkg::CSR_AGG_MODE: mode_ff <= csr_data[2:0];
               psva_pkg::CSR_LIFETIME: life_ff <= csr_data;
               default: ;
            endcase
         end
         if (pend_ff && (!obuf_ff || rsp_tready)) begin
            obuf_ff  <= 1'b1;
            odata_ff <= pdata_ff;
            pend_ff  <= 1'b0;
         end else if (obuf_ff && rsp_tready) begin
            obuf_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_IDLE: if (req_tvalid && req_tready) begin
               func_ff   <= req_tuser;
               addr_ff   <= req_tdata[31:0];
               sample_ff <= req_tdata[63:32];
               idx_ff    <= '0;
               hit_ff    <= (IW+1)'(SLOTS);
               free_ff   <= (IW+1)'(SLOTS);
               state_ff  <= (req_tuser == psva_pkg::FUNC_TICK) ? ST_TICK : ST_SRCH;
            end
            ST_SRCH, ST_TICK, ST_TICKW, ST_AGG: begin
               // issue one read per cycle, consume the previous one
               if (idx_ff < (IW+1)'(SLOTS)) begin
                  ridx_ff   <= idx_ff;
                  rvalid_ff <= 1'b1;
                  idx_ff    <= idx_ff + 1'b1;
               end else begin
                  rvalid_ff <= 1'b0;
               end
               if (state_ff == ST_TICK) state_ff <= ST_TICKW;
               if (state_ff == ST_TICKW && rvalid_ff && rd_live && tdec == 8'd0)
                  live_ff[ridx_ff[IW-1:0]] <= 1'b0;
               if (state_ff == ST_SRCH && rvalid_ff) begin
                  if (rd_live) begin
                     // first live match: compare its stored value now
                     if (hit_ff == (IW+1)'(SLOTS) && rd_addr == addr_ff) begin
                        hit_ff     <= ridx_ff;
                        changed_ff <= (rd_val != sample_ff);
                     end
                  end else if (free_ff == (IW+1)'(SLOTS)) free_ff <= ridx_ff;
               end
               if (state_ff == ST_AGG && rvalid_ff && rd_live) begin
                  acc_ff  <= acc_ff + rv_ext;
                  wsum_ff <= wsum_ff + rd_val;
                  n_ff    <= n_ff + 1'b1;
                  first_ff <= 1'b0;
                  if (first_ff ||
                      (mode_ff == psva_pkg::MODE_MIN && signed'(rd_val) < best_ff) ||
                      (mode_ff == psva_pkg::MODE_MAX && signed'(rd_val) > best_ff))
                     best_ff <= signed'(rd_val);
               end
               if (idx_ff == (IW+1)'(SLOTS) && !rvalid_ff && state_ff != ST_TICK) begin
                  unique case (state_ff)
                     ST_SRCH: state_ff <= ST_DECIDE;
                     ST_TICKW: state_ff <= ST_IDLE;
                     default: begin
                        if (mode_ff == psva_pkg::MODE_AVG && n_ff != '0) begin
                           neg_ff     <= acc_ff[AW-1];
                           div_num_ff <= acc_ff[AW-1] ? AW'(-acc_ff) : AW'(acc_ff);
                           rem_ff     <= '0;
                           quo_ff     <= '0;
                           dcnt_ff    <= 6'(AW);
                           state_ff   <= ST_DIV;
                        end else state_ff <= ST_OUT;
                     end
                  endcase
               end
            end
            ST_DECIDE: begin
               if (hit_ff != (IW+1)'(SLOTS)) begin
                  state_ff <= ST_WRITE;
               end else if (free_ff != (IW+1)'(SLOTS)) begin
                  hit_ff   <= free_ff;
                  idx_ff   <= free_ff;
                  changed_ff <= 1'b1;
                  live_ff[free_ff[IW-1:0]] <= 1'b1;
                  state_ff <= ST_WRITE;
               end else begin
                  pdata_ff <= {1'b0, 5'(CW'($countones(live_ff))), 1'b1, 1'b0, 32'd0};
                  pend_ff  <= 1'b1;
                  state_ff <= ST_IDLE;
               end
            end
            ST_WRITE: begin
               // entry is written this cycle; start the aggregate pass
               idx_ff   <= '0;
               acc_ff   <= '0;
               wsum_ff  <= '0;
               n_ff     <= '0;
               first_ff <= 1'b1;
               state_ff <= ST_AGG;
            end
            ST_DIV: begin
               div_num_ff <= {div_num_ff[AW-2:0], 1'b0};
               if (!dtrial[AW]) begin
                  rem_ff <= dtrial[AW-1:0];
                  quo_ff <= {quo_ff[AW-2:0], 1'b1};
               end else begin
                  rem_ff <= {rem_ff[AW-2:0], div_num_ff[AW-1]};
                  quo_ff <= {quo_ff[AW-2:0], 1'b0};
               end
               dcnt_ff <= dcnt_ff - 1'b1;
               if (dcnt_ff == 6'd1) state_ff <= ST_OUT;
            end
            ST_OUT: begin
               logic [31:0] v;
               v = 32'd0;
               if (n_ff != '0) begin
                  case (mode_ff) inside
                     psva_pkg::MODE_LAST: v = sample_ff;
                     psva_pkg::MODE_MIN, psva_pkg::MODE_MAX: v = best_ff;
                     psva_pkg::MODE_SUM: v = wsum_ff;
                     psva_pkg::MODE_AVG: v = neg_ff ? 32'(-quo_ff) : quo_ff[31:0];
                     default: v = 32'd0;
                  endcase
               end
               pdata_ff <= {1'b0, 5'(n_ff), 1'b0, changed_ff, v};
               pend_ff  <= 1'b1;
               state_ff <= ST_IDLE;
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   `ASSERT_IMPL(a_no_accept_busy, clock, reset, state_ff != ST_IDLE, !req_tready,
      "input accepted while busy")
   `ASSERT_NEXT(a_hold_out, clock, reset, rsp_tvalid && !rsp_tready,
      rsp_tvalid && $stable(rsp_tdata), "result lost under stall")
   `ASSERT_IMPL(a_pend_blocks, clock, reset, pend_ff, !req_tready,
      "accept while a result is pending")
endmodule
`default_nettype wire

// File: tb/per_source_value_aggregator_core_tb.sv
`default_nettype none
// ----------------------------------------------------------------------------
// per_source_value_aggregator_core_tb
// Drives report and tick items through the aggregator under varied
// backpressure and mode/lifetime settings, predicting each result with a
// behavioral copy of the source table and checking every rsp item by field.
// ----------------------------------------------------------------------------
module per_source_value_aggregator_core_tb;

   localparam int NSLOT = 16;
   localparam int WATCHDOG_LIMIT = 20000;

   typedef struct packed {
      logic        func;
      logic [31:0] addr;
      logic [31:0] sample;
   } req_item_type;

   typedef struct packed {
      logic [31:0] agg;
      logic        changed;
      logic        dropped;
      logic [4:0]  live;
   } rsp_item_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   wire         req_tready;
   logic [63:0] req_tdata = '0;
   logic        req_tuser = 1'b0;
   wire         rsp_tvalid;
   logic        rsp_tready = 1'b0;
   wire  [39:0] rsp_tdata;
   logic        csr_valid = 1'b0;
   wire         csr_ready;
   logic [0:0]  csr_index = '0;
   logic [7:0]  csr_data = '0;

   per_source_value_aggregator_core #(.SLOTS(NSLOT)) u_top (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_data(csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // predictor state
   logic [2:0]  cur_mode;
   logic [7:0]  cur_lifetime;
   logic [31:0] tbl_addr [NSLOT];
   logic [31:0] tbl_value [NSLOT];
   logic [7:0]  tbl_timer [NSLOT];
   logic        tbl_live [NSLOT];

   req_item_type pending_reqs[$];
   rsp_item_type expected_rsps[$];
   int          error_count = 0;
   int          send_idle_pct = 16;
   int          recv_idle_pct = 79;
   int          recv_hold = 0;
   int          quiet_cycles = 0;

   function automatic logic [4:0] live_total();
      int n;
      n = 0;
      for (int i = 0; i < NSLOT; i++) if (tbl_live[i]) n++;
      return n[4:0];
   endfunction

   function automatic logic [31:0] table_aggregate(logic [31:0] last);
      longint acc, best, v;
      logic [31:0] wsum;
      int n;
      acc = 0; best = 0; wsum = '0; n = 0;
      for (int i = 0; i < NSLOT; i++) begin
         if (tbl_live[i]) begin
            v = longint'($signed(tbl_value[i]));
            if (n == 0) best = v;
            else if (cur_mode == psva_pkg::MODE_MIN && v < best) best = v;
            else if (cur_mode == psva_pkg::MODE_MAX && v > best) best = v;
            acc += v;
            wsum += tbl_value[i];
            n++;
         end
      end
      if (n == 0) return '0;
      case (cur_mode) inside
         psva_pkg::MODE_LAST: return last;
         psva_pkg::MODE_MIN, psva_pkg::MODE_MAX: return best[31:0];
         psva_pkg::MODE_SUM: return wsum;
         psva_pkg::MODE_AVG: begin
            acc = acc / n;
            return acc[31:0];
         end
         default: return '0;
      endcase
   endfunction

   task automatic apply_item(input req_item_type it);
      int hit, free_slot;
      rsp_item_type r;
      if (it.func == psva_pkg::FUNC_TICK) begin
         for (int i = 0; i < NSLOT; i++) begin
            if (tbl_live[i]) begin
               if (tbl_timer[i] > 0) tbl_timer[i]--;
               if (tbl_timer[i] == 0) tbl_live[i] = 1'b0;
            end
         end
         return;
      end
      hit = NSLOT; free_slot = NSLOT;
      for (int i = 0; i < NSLOT; i++) begin
         if (tbl_live[i]) begin
            if (hit == NSLOT && tbl_addr[i] == it.addr) hit = i;
         end else if (free_slot == NSLOT) free_slot = i;
      end
      r = '0;
      if (hit < NSLOT) begin
         r.changed = (tbl_value[hit] != it.sample);
      end else if (free_slot < NSLOT) begin
         hit = free_slot;
         tbl_live[hit] = 1'b1;
         tbl_addr[hit] = it.addr;
         r.changed = 1'b1;
      end else begin
         r.dropped = 1'b1;
         r.live = live_total();
         expected_rsps.push_back(r);
         return;
      end
      tbl_timer[hit] = cur_lifetime;
      tbl_value[hit] = it.sample;
      r.agg = table_aggregate(it.sample);
      r.live = live_total();
      expected_rsps.push_back(r);
   endtask

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("ERROR %0t: %s got %0h expected %0h", $time, what, got, want);
      error_count++;
   endtask

   // driver
   always @(negedge clock) begin
      if (!reset) begin
         if (req_tvalid && !req_tready) begin
            // hold the offered item
         end else if (pending_reqs.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
            req_tvalid <= 1'b1;
            req_tuser  <= pending_reqs[0].func;
            req_tdata  <= {pending_reqs[0].sample, pending_reqs[0].addr};
            void'(pending_reqs.pop_front());
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // receiver
   always @(negedge clock) begin
      if (!reset) begin
         if (recv_hold > 0) begin
            rsp_tready <= 1'b0;
            recv_hold--;
         end else begin
            rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      rsp_item_type got, want;
      if (!reset) begin
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
            quiet_cycles <= 0;
         else
            quiet_cycles <= quiet_cycles + 1;
         if (req_tvalid && req_tready) begin
            apply_item('{func: req_tuser, addr: req_tdata[31:0],
                         sample: req_tdata[63:32]});
         end
         if (rsp_tvalid && rsp_tready) begin
            got = '{agg: rsp_tdata[31:0], changed: rsp_tdata[32],
                    dropped: rsp_tdata[33], live: rsp_tdata[38:34]};
            if (expected_rsps.size() == 0) begin
               report_mismatch("unexpected rsp item", rsp_tdata[31:0], '0);
            end else begin
               want = expected_rsps.pop_front();
               if (got.agg != want.agg) report_mismatch("agg_value", got.agg, want.agg);
               if (got.changed != want.changed)
                  report_mismatch("changed", 32'(got.changed), 32'(want.changed));
               if (got.dropped != want.dropped)
                  report_mismatch("dropped", 32'(got.dropped), 32'(want.dropped));
               if (got.live != want.live)
                  report_mismatch("live_count", 32'(got.live), 32'(want.live));
            end
         end
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
         end
      end
   end

   // address pool keeps hits frequent; a few wide random addresses mixed in
   logic [31:0] addr_pool [24];

   function automatic req_item_type make_report(logic [31:0] a, logic [31:0] s);
      return '{func: psva_pkg::FUNC_REPORT, addr: a, sample: s};
   endfunction

   function automatic req_item_type make_tick();
      return '{func: psva_pkg::FUNC_TICK, addr: $urandom(), sample: $urandom()};
   endfunction

   task automatic drain();
      while (pending_reqs.size() > 0 || req_tvalid || expected_rsps.size() > 0)
         @(posedge clock);
      // let a trailing tick sweep finish
      repeat (60) @(posedge clock);
   endtask

   task automatic write_reg(input logic [0:0] idx, input logic [7:0] val);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      if (idx == psva_pkg::CSR_AGG_MODE) cur_mode = val[2:0];
      else cur_lifetime = val;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic random_phase(input int n);
      logic [31:0] s;
      int k;
      for (int i = 0; i < n; i++) begin
         k = $urandom_range(99);
         case ($urandom_range(3))
            0: s = $urandom();
            1: s = 32'h7fffffff - $urandom_range(3);
            2: s = 32'h80000000 + $urandom_range(3);
            default: s = $urandom_range(20) - 10;
         endcase
         if (k < 12) pending_reqs.push_back(make_tick());
         else if (k < 20) pending_reqs.push_back(make_report($urandom(), s));
         else pending_reqs.push_back(make_report(addr_pool[5'($urandom_range(23))], s));
      end
   endtask

   initial begin
      for (int i = 0; i < NSLOT; i++) begin
         tbl_live[i] = 1'b0; tbl_addr[i] = '0; tbl_value[i] = '0; tbl_timer[i] = '0;
      end
      cur_mode = psva_pkg::MODE_LAST;
      cur_lifetime = psva_pkg::LIFETIME_RESET;
      for (int i = 0; i < 24; i++) addr_pool[i] = $urandom();
      addr_pool[0] = 32'h0;
      addr_pool[1] = 32'hffffffff;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: extremes, unchanged report, full table, undefined mode
      write_reg(psva_pkg::CSR_AGG_MODE, 8'(psva_pkg::MODE_SUM));
      write_reg(psva_pkg::CSR_LIFETIME, 8'd255);
      pending_reqs.push_back(make_report(32'h0, 32'h7fffffff));
      pending_reqs.push_back(make_report(32'hffffffff, 32'h80000000));
      pending_reqs.push_back(make_report(32'hffffffff, 32'h80000000));
      for (int i = 0; i < 15; i++)
         pending_reqs.push_back(make_report(32'h100 + i, 32'hffffffff));
      pending_reqs.push_back(make_tick());
      drain();
      write_reg(psva_pkg::CSR_AGG_MODE, 8'd7);
      pending_reqs.push_back(make_report(32'h0, 32'h1));
      drain();
      write_reg(psva_pkg::CSR_AGG_MODE, 8'(psva_pkg::MODE_AVG));
      pending_reqs.push_back(make_report(32'h0, 32'h80000000));
      drain();
      write_reg(psva_pkg::CSR_LIFETIME, 8'd1);
      pending_reqs.push_back(make_tick());
      pending_reqs.push_back(make_tick());
      pending_reqs.push_back(make_report(32'h5, 32'hfffffffb));
      drain();

      // random phases, varying idling and settings
      send_idle_pct = 16; recv_idle_pct = 79;
      write_reg(psva_pkg::CSR_AGG_MODE, 8'(psva_pkg::MODE_MIN));
      write_reg(psva_pkg::CSR_LIFETIME, 8'd3);
      random_phase(80);
      recv_hold = 400;
      drain();

      send_idle_pct = 79; recv_idle_pct = 16;
      write_reg(psva_pkg::CSR_AGG_MODE, 8'(psva_pkg::MODE_MAX));
      write_reg(psva_pkg::CSR_LIFETIME, 8'd8);
      random_phase(80);
      drain();

      send_idle_pct = 0; recv_idle_pct = 0;
      write_reg(psva_pkg::CSR_AGG_MODE, 8'(psva_pkg::MODE_AVG));
      write_reg(psva_pkg::CSR_LIFETIME, 8'd5);
      random_phase(80);
      drain();
      write_reg(psva_pkg::CSR_AGG_MODE, 8'(psva_pkg::MODE_LAST));
      write_reg(psva_pkg::CSR_LIFETIME, 8'd255);
      random_phase(70);
      drain();
      write_reg(psva_pkg::CSR_AGG_MODE, 8'(psva_pkg::MODE_SUM));
      write_reg(psva_pkg::CSR_LIFETIME, 8'd2);
      random_phase(116);
      drain();

      if (error_count == 0) $display("Simulation PASSED");
      else $display("Simulation FAILED");
      $finish;
   end
endmodule
`default_nettype wire

// File: sim.f
+incdir+sv
sv/psva_pkg.sv
sv/per_source_value_aggregator_core.sv
tb/per_source_value_aggregator_core_tb.sv
